/* hdl/bsa_pkg.sv */
// Shared types and codes for the bitmap slot allocator.
package bsa_pkg;

  localparam int WORD_BITS = 64;
  localparam int WIDX_W    = 5;    // word index width; committed count never exceeds 32 words
  localparam int SLOT_W    = 11;   // internal slot number width
  localparam int ADDR_W    = 48;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_BATCH = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_FREE     = 2'd1;
  localparam logic [1:0] ST_NOT_OWNED   = 2'd2;
  localparam logic [1:0] ST_DOUBLE_FREE = 2'd3;

  localparam logic [1:0] CFG_COMMITTED = 2'd0;
  localparam logic [1:0] CFG_SHIFT     = 2'd1;
  localparam logic [1:0] CFG_BASE      = 2'd2;

  // bitmap write request
  typedef struct packed {
    logic                 clr;
    logic                 we;
    logic [WIDX_W-1:0]    word;
    logic [WORD_BITS-1:0] data;
  } bsa_wr_t;

  // finder result for one word
  typedef struct packed {
    logic                 hit;
    logic [5:0]           bit_idx;
    logic [WORD_BITS-1:0] word_new;
    logic                 full;
  } bsa_hit_t;

endpackage

/* hdl/bsa_bitmap.sv */
// Occupancy bitmap: one flop word per 64 slots, cleared by reset or a clear request.
module bsa_bitmap
  import bsa_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bsa_wr_t              wr,
  input  logic [WIDX_W-1:0]    rd_word,
  output logic [WORD_BITS-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_BITS-1:0] words [DEPTH];

  // a write beats a clear so a pool reset can mark the tail word in the same cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (rst) begin
        words[i] <= '0;
      end else if (wr.we && (wr.word[AW-1:0] == AW'(i))) begin
        words[i] <= wr.data;
      end else if (wr.clr) begin
        words[i] <= '0;
      end
    end
  end

  assign rd_data = words[rd_word[AW-1:0]];

endmodule

/* hdl/bsa_find.sv */
// Finder: lowest free, committed bit of one bitmap word and the word after claiming it.
module bsa_find
  import bsa_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  logic [WIDX_W-1:0]    word_idx,
  input  logic [SLOT_W-1:0]    committed,
  output bsa_hit_t             hit
);

  logic [SLOT_W-1:0]    lo;
  logic [SLOT_W-1:0]    rem;
  logic [WORD_BITS-1:0] vmask;
  logic [WORD_BITS-1:0] avail;
  logic [5:0]           idx;

  assign lo  = {word_idx, 6'd0};
  assign rem = committed - lo;

  always_comb begin
    if (committed <= lo) begin
      vmask = '0;
    end else if (rem >= SLOT_W'(WORD_BITS)) begin
      vmask = '1;
    end else begin
      vmask = (64'd1 << rem[5:0]) - 64'd1;
    end
  end

  assign avail = ~word & vmask;

  always_comb begin
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        idx = 6'(i);
      end
    end
  end

  assign hit.hit      = |avail;
  assign hit.bit_idx  = idx;
  assign hit.word_new = word | (64'd1 << idx);
  assign hit.full     = &hit.word_new;

endmodule

/* hdl/bitmap_slot_allocator.sv */
// Top level: bitmap slot allocator with next-fit scan sequencer.
//
//  channel  | signals                                         | transfer when
//  ---------+-------------------------------------------------+---------------------------
//  command  | start, busy, command, free_address, batch_count | start && !busy at clk edge
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data       | cfg_valid && cfg_ready
//  result   | result_valid, status, block_address,            | every cycle result_valid
//           | slot_index, free_slots, last                    | is high (one cycle each)
//
// Steps: alloc scans the bitmap words from the hint, granting a slot on each hit, then
// closes out in S_FLUSH (or reports no free slot); the finder handles one word read per
// cycle. Free checks the address in S_FCHK and the bit in S_FBIT; pool reset finishes from
// idle. Each result is registered and shows in the cycle after the one that produced it.
// Reset (rst, synchronous) clears the bitmap and hint, resets the free count and loads register
// defaults. The receiver cannot stall: results are strobed for exactly one cycle.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int POOL_SIZE = 1024,
  parameter int MAX_BATCH = 64
) (
  input  logic              clk,
  input  logic              rst,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [ADDR_W-1:0] free_address,
  input  logic [6:0]        batch_count,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  // result channel
  output logic              result_valid,
  output logic [1:0]        status,
  output logic [ADDR_W-1:0] block_address,
  output logic [9:0]        slot_index,
  output logic [10:0]       free_slots,
  output logic              last
);

  localparam int NWORDS = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
  // committed count is 11 bits, so at most 32 words are ever reachable
  localparam int DEPTH  = (NWORDS > 32) ? 32 : NWORDS;
  localparam int CAP    = (POOL_SIZE > 2047) ? 2047 : POOL_SIZE;
  localparam int FC_RST = (POOL_SIZE < 1024) ? POOL_SIZE : 1024;

  localparam logic [SLOT_W-1:0] CAP_C    = SLOT_W'(CAP);
  localparam logic [SLOT_W-1:0] FC_RST_C = SLOT_W'(FC_RST);
  localparam logic [6:0]        MAXB_C   = 7'(MAX_BATCH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_FCHK  = 3'd3;
  localparam logic [2:0] S_FBIT  = 3'd4;

  // configuration registers
  logic [SLOT_W-1:0] committed;
  logic [4:0]        block_shift;
  logic [ADDR_W-1:0] payload_base;

  // sequencer state
  logic [2:0]        state, state_next;
  logic [6:0]        want, want_next;
  logic [6:0]        found, found_next;
  logic [WIDX_W-1:0] cur_w, cur_w_next;
  logic [WIDX_W-1:0] steps, steps_next;
  logic              pend_valid, pend_valid_next;
  logic [SLOT_W-1:0] pend_slot, pend_slot_next;
  logic [WIDX_W-1:0] hint, hint_next;
  logic [SLOT_W-1:0] free_total, free_total_next;
  logic [ADDR_W:0]   off, off_next;
  logic [SLOT_W-1:0] fslot, fslot_next;

  // emit request for the result register
  logic              emit;
  logic [1:0]        e_status;
  logic              e_grant;
  logic [SLOT_W-1:0] e_slot;
  logic              e_last;
  logic [ADDR_W-1:0] e_addr;

  // derived pool geometry
  logic [SLOT_W-1:0] c_eff;
  logic [5:0]        nw;
  logic [5:0]        tail;
  logic [6:0]        want_in;

  logic [ADDR_W-1:0] sh_off;
  logic [ADDR_W-1:0] align_mask;

  bsa_wr_t              wr;
  logic [WIDX_W-1:0]    rd_word;
  logic [WORD_BITS-1:0] rd_data;
  bsa_hit_t             fhit;

  assign c_eff = (committed > CAP_C) ? CAP_C : committed;
  assign nw    = 6'((12'(c_eff) + 12'd63) >> 6);
  assign tail  = c_eff[5:0];

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign want_in = (command == CMD_ALLOC) ? 7'd1 :
                   ((batch_count > MAXB_C) ? MAXB_C : batch_count);

  assign sh_off     = off[ADDR_W-1:0] >> block_shift;
  assign align_mask = ~({ADDR_W{1'b1}} << block_shift);

  assign rd_word = (state == S_FBIT) ? fslot[10:6] : cur_w;

  bsa_bitmap #(
    .DEPTH (DEPTH)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_word (rd_word),
    .rd_data (rd_data)
  );

  bsa_find u_find (
    .word      (rd_data),
    .word_idx  (cur_w),
    .committed (c_eff),
    .hit       (fhit)
  );

  // sequencer
  always_comb begin
    state_next      = state;
    want_next       = want;
    found_next      = found;
    cur_w_next      = cur_w;
    steps_next      = steps;
    pend_valid_next = pend_valid;
    pend_slot_next  = pend_slot;
    hint_next       = hint;
    free_total_next = free_total;
    off_next        = off;
    fslot_next      = fslot;
    emit     = 1'b0;
    e_status = ST_OK;
    e_grant  = 1'b0;
    e_slot   = '0;
    e_last   = 1'b0;
    wr.clr   = 1'b0;
    wr.we    = 1'b0;
    wr.word  = cur_w;
    wr.data  = fhit.word_new;

    case (state)
      S_IDLE: begin
        if (start) begin
          case (command)
            CMD_ALLOC, CMD_BATCH: begin
              if (want_in != 7'd0) begin
                if (nw == 6'd0) begin
                  emit     = 1'b1;
                  e_status = ST_NO_FREE;
                  e_last   = 1'b1;
                end else begin
                  // stale hint restarts at word zero
                  if ({1'b0, hint} >= nw) begin
                    hint_next  = '0;
                    cur_w_next = '0;
                  end else begin
                    cur_w_next = hint;
                  end
                  want_next       = want_in;
                  found_next      = '0;
                  steps_next      = '0;
                  pend_valid_next = 1'b0;
                  state_next      = S_SCAN;
                end
              end
            end
            CMD_FREE: begin
              off_next   = {1'b0, free_address} - {1'b0, payload_base};
              state_next = S_FCHK;
            end
            CMD_RESET: begin
              wr.clr = 1'b1;
              if (tail != 6'd0 && nw != 6'd0) begin
                wr.we   = 1'b1;
                wr.word = WIDX_W'(nw - 6'd1);
                wr.data = {WORD_BITS{1'b1}} << tail;
              end
              free_total_next = c_eff;
              emit            = 1'b1;
              e_status        = ST_OK;
              e_last          = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (fhit.hit) begin
          wr.we = 1'b1;
          if (fhit.full) begin
            hint_next = cur_w + WIDX_W'(1);
          end
          // previous grant is known not to be last
          if (pend_valid) begin
            emit            = 1'b1;
            e_status        = ST_OK;
            e_grant         = 1'b1;
            e_slot          = pend_slot;
            free_total_next = (free_total == '0) ? '0 : free_total - SLOT_W'(1);
          end
          pend_valid_next = 1'b1;
          pend_slot_next  = {cur_w, fhit.bit_idx};
          found_next      = 7'(found + 7'd1);
          if (7'(found + 7'd1) == want) begin
            state_next = S_FLUSH;
          end
        end else if ({1'b0, steps} == nw - 6'd1) begin
          if (pend_valid) begin
            state_next = S_FLUSH;
          end else begin
            emit       = 1'b1;
            e_status   = ST_NO_FREE;
            e_last     = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          steps_next = steps + WIDX_W'(1);
          if (6'({1'b0, cur_w}) + 6'd1 == nw) begin
            cur_w_next = '0;
          end else begin
            cur_w_next = cur_w + WIDX_W'(1);
          end
        end
      end

      S_FLUSH: begin
        emit            = 1'b1;
        e_status        = ST_OK;
        e_grant         = 1'b1;
        e_slot          = pend_slot;
        e_last          = 1'b1;
        free_total_next = (free_total == '0) ? '0 : free_total - SLOT_W'(1);
        state_next      = S_IDLE;
      end

      S_FCHK: begin
        // below base, misaligned or beyond committed pool
        if (off[ADDR_W] || ((off[ADDR_W-1:0] & align_mask) != '0) ||
            (sh_off >= ADDR_W'(c_eff))) begin
          emit       = 1'b1;
          e_status   = ST_NOT_OWNED;
          e_last     = 1'b1;
          state_next = S_IDLE;
        end else begin
          fslot_next = sh_off[SLOT_W-1:0];
          state_next = S_FBIT;
        end
      end

      S_FBIT: begin
        emit   = 1'b1;
        e_slot = fslot;
        e_last = 1'b1;
        if (!rd_data[fslot[5:0]]) begin
          e_status = ST_DOUBLE_FREE;
        end else begin
          e_status        = ST_OK;
          wr.we           = 1'b1;
          wr.word         = fslot[10:6];
          wr.data         = rd_data & ~(64'd1 << fslot[5:0]);
          free_total_next = (free_total == 11'h7FF) ? free_total : free_total + SLOT_W'(1);
        end
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // granted address wraps to 48 bits
  assign e_addr = e_grant ? ADDR_W'(payload_base + (ADDR_W'(e_slot) << block_shift)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pend_valid   <= 1'b0;
      hint         <= '0;
      free_total   <= FC_RST_C;
      result_valid <= 1'b0;
      committed    <= SLOT_W'(1024);
      block_shift  <= 5'd6;
      payload_base <= '0;
    end else begin
      state        <= state_next;
      pend_valid   <= pend_valid_next;
      hint         <= hint_next;
      free_total   <= free_total_next;
      result_valid <= emit;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_COMMITTED: committed    <= cfg_data[SLOT_W-1:0];
          CFG_SHIFT:     block_shift  <= cfg_data[4:0];
          CFG_BASE:      payload_base <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    want      <= want_next;
    found     <= found_next;
    cur_w     <= cur_w_next;
    steps     <= steps_next;
    pend_slot <= pend_slot_next;
    off       <= off_next;
    fslot     <= fslot_next;
    if (emit) begin
      status        <= e_status;
      block_address <= e_addr;
      slot_index    <= e_slot[9:0];
      free_slots    <= free_total_next;
      last          <= e_last;
    end
  end

endmodule

/* tb/sv/bitmap_slot_allocator_test.sv */
// Self-checking testbench for the bitmap slot allocator: pool tracker, drivers, checker.
module bitmap_slot_allocator_test;
  import bsa_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 9;
  localparam int POOL_SLOTS     = 1024;
  localparam int POOL_WORDS     = POOL_SLOTS / WORD_BITS;
  localparam int BATCH_CAP      = 64;
  localparam int REPORT_LIMIT   = 10;
  // Settle well past the longest busy stretch, a full batch scan.
  localparam int SETTLE_CYCLES  = 100;
  localparam int DRAIN_LIMIT    = 5000;
  // Timeout covers roughly 280 items, each at its longest busy stretch and gap, about 10x over.
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int PHASE_ITEMS    = 41;

  // Register index with no register behind it; writes must be ignored.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] address;
    logic [9:0]        slot;
    logic [10:0]       free_left;
    logic              last;
  } reply_t;

  // Mirror of the pool: registers, bitmap, next-fit hint, free count, and the
  // replies still owed by the block in transfer order.
  class slot_pool_board;
    logic [10:0]          committed;
    logic [4:0]           shift;
    logic [ADDR_W-1:0]    base;
    logic [WORD_BITS-1:0] bitmap [POOL_WORDS];
    logic [4:0]           hint;
    logic [10:0]          free_left;
    reply_t               replies_due [$];
    int                   faults;

    function new();
      faults = 0;
      committed = 11'd1024;
      shift = 5'd6;
      base = '0;
      foreach (bitmap[i]) bitmap[i] = '0;
      hint = '0;
      free_left = 11'(usable());
    endfunction

    // Committed count clipped to the physical pool.
    function int usable();
      return (committed > 11'(POOL_SLOTS)) ? POOL_SLOTS : int'(committed);
    endfunction

    function logic [ADDR_W-1:0] addr_of(int slot);
      logic [63:0] wide;
      wide = 64'(base) + (64'(slot) << shift);
      return wide[ADDR_W-1:0];
    endfunction

    function void write_reg(logic [1:0] idx, logic [ADDR_W-1:0] data);
      case (idx)
        CFG_COMMITTED: committed = data[10:0];
        CFG_SHIFT:     shift = data[4:0];
        CFG_BASE:      base = data;
        default: ;
      endcase
    endfunction

    function void owe(logic [1:0] st, logic [ADDR_W-1:0] a, int slot, logic fin);
      reply_t r;
      r.status = st;
      r.address = a;
      r.slot = 10'(slot);
      r.free_left = free_left;
      r.last = fin;
      replies_due.push_back(r);
    endfunction

    function void predict_replies(logic [1:0] cmd, logic [ADDR_W-1:0] addr, logic [6:0] count);
      int c, nw, want, w, lo, first_word, i, k;
      int granted [$];
      logic [63:0] avail, mask, off, slot;
      logic any;
      c = usable();
      nw = (c + 63) / 64;
      case (cmd)
        CMD_ALLOC, CMD_BATCH: begin
          want = (cmd == CMD_ALLOC) ? 1 : ((count > 7'(BATCH_CAP)) ? BATCH_CAP : int'(count));
          if (want == 0) return;
          if (nw > 0) begin
            // stale hint restarts the scan at word 0
            if (hint >= nw) hint = '0;
            first_word = hint;
            for (i = 0; i < nw && granted.size() < want; i++) begin
              w = first_word + i;
              if (w >= nw) w -= nw;
              lo = w * 64;
              if (c <= lo) mask = '0;
              else if (c - lo >= 64) mask = ~64'd0;
              else mask = (64'd1 << (c - lo)) - 64'd1;
              avail = ~bitmap[w] & mask;
              any = 1'b0;
              for (k = 0; k < 64 && granted.size() < want; k++) begin
                if (avail[k]) begin
                  bitmap[w][k] = 1'b1;
                  granted.push_back(w * 64 + k);
                  any = 1'b1;
                end
              end
              if (any && bitmap[w] == ~64'd0) hint = 5'(w + 1);
            end
          end
          if (granted.size() == 0) begin
            owe(ST_NO_FREE, '0, 0, 1'b1);
          end else begin
            foreach (granted[j]) begin
              if (free_left > 0) free_left--;
              owe(ST_OK, addr_of(granted[j]), granted[j], j == granted.size() - 1);
            end
          end
        end
        CMD_FREE: begin
          if (addr < base) begin
            owe(ST_NOT_OWNED, '0, 0, 1'b1);
          end else begin
            off = 64'(addr - base);
            slot = off >> shift;
            if ((off & ((64'd1 << shift) - 64'd1)) != 0 || slot >= 64'(c)) begin
              owe(ST_NOT_OWNED, '0, 0, 1'b1);
            end else if (!bitmap[slot[9:6]][slot[5:0]]) begin
              owe(ST_DOUBLE_FREE, '0, int'(slot), 1'b1);
            end else begin
              bitmap[slot[9:6]][slot[5:0]] = 1'b0;
              if (free_left < 11'd2047) free_left++;
              owe(ST_OK, '0, int'(slot), 1'b1);
            end
          end
        end
        CMD_RESET: begin
          for (w = 0; w < POOL_WORDS; w++) bitmap[w] = '0;
          // slots past the committed count in its last word are marked taken
          if ((c % 64) != 0 && nw > 0) bitmap[nw - 1] = ~64'd0 << (c % 64);
          free_left = 11'(c);
          owe(ST_OK, '0, 0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_reply(reply_t got);
      reply_t oldest;
      if (replies_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("unexpected reply: st=%0d addr=%h slot=%0d free=%0d last=%0b",
                   got.status, got.address, got.slot, got.free_left, got.last);
        return;
      end
      oldest = replies_due.pop_front();
      if (got.status !== oldest.status || got.address !== oldest.address ||
          got.slot !== oldest.slot || got.free_left !== oldest.free_left ||
          got.last !== oldest.last) begin
        faults++;
        if (faults <= REPORT_LIMIT) begin
          $display("reply mismatch: exp st=%0d addr=%h slot=%0d free=%0d last=%0b",
                   oldest.status, oldest.address, oldest.slot, oldest.free_left,
                   oldest.last);
          $display("                got st=%0d addr=%h slot=%0d free=%0d last=%0b",
                   got.status, got.address, got.slot, got.free_left, got.last);
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        command = CMD_ALLOC;
  logic [ADDR_W-1:0] free_address = '0;
  logic [6:0]        batch_count = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_COMMITTED;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              result_valid;
  logic [1:0]        status;
  logic [ADDR_W-1:0] block_address;
  logic [9:0]        slot_index;
  logic [10:0]       free_slots;
  logic              last;

  slot_pool_board pool;
  bit steady = 1'b0;   // no sender gaps while set

  bitmap_slot_allocator dut (.*);

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Results are strobed for one cycle and cannot be held off: sample every edge.
  // Outputs are read before this edge's updates land, so no ordering race.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      reply_t got;
      got.status = status;
      got.address = block_address;
      got.slot = slot_index;
      got.free_left = free_slots;
      got.last = last;
      pool.check_reply(got);
    end
  end

  function automatic logic [ADDR_W-1:0] rnd48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [ADDR_W-1:0] rand_base(int sh, bit align);
    logic [ADDR_W-1:0] b;
    b = rnd48();
    if (align) b = b & ~((48'd1 << sh) - 48'd1);
    return b;
  endfunction

  // One command transfer: hold start until busy is low at an edge, then
  // predict. start stays high when the next item follows with no gap.
  task automatic send_cmd(logic [1:0] cmd, logic [ADDR_W-1:0] addr, logic [6:0] count);
    int gap;
    start <= 1'b1;
    command <= cmd;
    free_address <= addr;
    batch_count <= count;
    do @(posedge clk); while (busy !== 1'b0);
    pool.predict_replies(cmd, addr, count);
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 30)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write transfer; valid drops for a cycle before the next write.
  task automatic write_reg(logic [1:0] idx, logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    pool.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits above a register's width are junk half the time.
  task automatic configure(int c, int sh, logic [ADDR_W-1:0] b);
    logic [ADDR_W-1:0] junk;
    junk = rnd48();
    write_reg(CFG_COMMITTED, $urandom_range(0, 1) ? ((junk & ~48'h7FF) | 48'(c)) : 48'(c));
    junk = rnd48();
    write_reg(CFG_SHIFT, $urandom_range(0, 1) ? ((junk & ~48'h1F) | 48'(sh)) : 48'(sh));
    write_reg(CFG_BASE, b);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, rnd48());
  endtask

  // Stop sending, wait for every owed reply, then let the block settle. Replies
  // that never come are failures.
  task automatic quiesce();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (pool.replies_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pool.replies_due.size() != 0) begin
      pool.faults += pool.replies_due.size();
      $display("missing %0d replies", pool.replies_due.size());
      pool.replies_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_item();
    int pick, c, slot, t;
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] a;
    logic [6:0]        n;
    c = pool.usable();
    a = rnd48();
    n = 7'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      cmd = CMD_ALLOC;
    end else if (pick < 52) begin
      cmd = CMD_BATCH;
      pick = $urandom_range(0, 99);
      if (pick < 70) n = 7'($urandom_range(1, 8));
      else if (pick < 90) n = 7'($urandom_range(9, 64));
      else if (pick < 96) n = 7'($urandom_range(65, 127));
      else n = '0;
    end else if (pick < 95) begin
      cmd = CMD_FREE;
      pick = $urandom_range(0, 99);
      if (c > 0 && pick < 70) begin
        // aim at a slot that is currently held
        slot = 0;
        for (t = 0; t < 16; t++) begin
          slot = $urandom_range(0, c - 1);
          if (pool.bitmap[slot / 64][slot % 64]) break;
        end
        a = pool.addr_of(slot);
      end else if (c > 0 && pick < 85) begin
        a = pool.addr_of($urandom_range(0, c - 1));
      end else begin
        case ($urandom_range(0, 2))
          0: ;
          1: a = pool.addr_of($urandom_range(0, POOL_SLOTS - 1)) + 48'd1;
          default: a = pool.base - 48'($urandom_range(1, 1000));
        endcase
      end
    end else begin
      cmd = CMD_RESET;
    end
    send_cmd(cmd, a, n);
  endtask

  initial begin
    int phase, sh;
    pool = new;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: 1024 slots, 64-byte blocks, base zero.
    send_cmd(CMD_ALLOC, rnd48(), 7'($urandom));     // slot 0
    send_cmd(CMD_BATCH, rnd48(), 7'd5);
    send_cmd(CMD_BATCH, rnd48(), 7'd0);             // answers nothing
    send_cmd(CMD_BATCH, rnd48(), 7'd127);           // capped, fills word 0, hint moves
    send_cmd(CMD_FREE, pool.addr_of(0), 7'($urandom));
    send_cmd(CMD_FREE, pool.addr_of(0), 7'($urandom));   // double free
    send_cmd(CMD_FREE, 48'd1, 7'($urandom));             // misaligned
    send_cmd(CMD_FREE, pool.addr_of(POOL_SLOTS), 7'($urandom));  // past committed
    send_cmd(CMD_FREE, 48'hFFFF_FFFF_FFFF, 7'($urandom));
    send_cmd(CMD_ALLOC, rnd48(), 7'($urandom));     // next fit skips freed slot 0
    send_cmd(CMD_RESET, rnd48(), 7'($urandom));
    quiesce();

    // Partial last word, 8-byte blocks, base near the top so addresses wrap.
    configure(70, 3, 48'hFFFF_FFFF_FF00);
    send_cmd(CMD_RESET, rnd48(), 7'($urandom));     // tail bits of word 1 marked
    send_cmd(CMD_BATCH, rnd48(), 7'd64);
    send_cmd(CMD_BATCH, rnd48(), 7'd64);            // short batch, hint goes stale
    send_cmd(CMD_ALLOC, rnd48(), 7'($urandom));     // pool exhausted
    send_cmd(CMD_FREE, 48'd0, 7'($urandom));        // below base
    send_cmd(CMD_FREE, pool.addr_of(3), 7'($urandom));
    send_cmd(CMD_ALLOC, rnd48(), 7'($urandom));
    quiesce();

    // Nothing committed.
    configure(0, 0, rnd48());
    write_reg(CFG_UNUSED, rnd48());
    send_cmd(CMD_ALLOC, rnd48(), 7'($urandom));
    send_cmd(CMD_BATCH, rnd48(), 7'd1);
    send_cmd(CMD_FREE, pool.base, 7'($urandom));
    send_cmd(CMD_RESET, rnd48(), 7'($urandom));
    quiesce();

    // Free count of 64 while the pool is raised past its size: count floors at zero.
    configure(64, 31, 48'd0);
    send_cmd(CMD_RESET, rnd48(), 7'($urandom));
    quiesce();
    write_reg(CFG_COMMITTED, 48'd2047);             // clipped to the pool size
    send_cmd(CMD_BATCH, rnd48(), 7'd64);
    send_cmd(CMD_BATCH, rnd48(), 7'd64);
    send_cmd(CMD_FREE, pool.addr_of(200), 7'($urandom));
    quiesce();

    // Random phases, each under its own register setting.
    for (phase = 0; phase < 6; phase++) begin
      steady = (phase == 2);
      case (phase)
        0: configure(POOL_SLOTS, 3, 48'd0);
        1: configure(1, 20, 48'hFFFF_FFF0_0000);
        2: begin
          sh = $urandom_range(3, 20);
          configure($urandom_range(65, 200), sh, rand_base(sh, 1'b1));
        end
        3: configure(POOL_SLOTS, 0, rand_base(0, 1'b0));
        default: begin
          sh = $urandom_range(0, 31);
          configure($urandom_range(0, 2047), sh, rand_base(sh, $urandom_range(0, 3) != 0));
        end
      endcase
      // phase 4 keeps the old bitmap under the new setting
      if (phase != 4) send_cmd(CMD_RESET, rnd48(), 7'($urandom));
      repeat (PHASE_ITEMS) send_random_item();
      quiesce();
    end

    if (pool.faults == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
